/* rtl/core/imrm_pkg.sv */
package imrm_pkg;

  localparam int unsigned TagW = 32;
  localparam int unsigned LenW = 16;
  localparam int unsigned HandleW = 16;
  localparam int unsigned CookieW = 32;
  localparam int unsigned EventW = 3;
  localparam logic [TagW-1:0] Wildcard = '1;

  typedef enum logic [EventW-1:0] {
    EV_XFER   = 3'd0,
    EV_SMALL  = 3'd1,
    EV_DESC   = 3'd2,
    EV_QUEUED = 3'd3,
    EV_DROP   = 3'd4
  } event_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_EMIT,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic              kind;
    logic [TagW-1:0]   tag;
    logic [TagW-1:0]   seq;
    logic [LenW-1:0]   len;
    logic [HandleW-1:0] handle;
    logic [CookieW-1:0] cookie;
  } entry_t;

  typedef struct packed {
    logic shift;
    logic append;
  } cell_ctrl_t;

endpackage

/* rtl/core/imrm_if.sv */
interface imrm_in_if;
  logic                          valid;
  logic                          ready;
  logic                          op;
  logic                          kind;
  logic signed [imrm_pkg::TagW-1:0] tag;
  logic signed [imrm_pkg::TagW-1:0] sequence_req;
  logic [imrm_pkg::LenW-1:0]     length;
  logic [imrm_pkg::HandleW-1:0]  payload_handle;
  logic [imrm_pkg::CookieW-1:0]  request_cookie;
  modport source (output valid, op, kind, tag, sequence_req, length, payload_handle,
                  request_cookie, input ready);
  modport sink (input valid, op, kind, tag, sequence_req, length, payload_handle,
                request_cookie, output ready);
endinterface

interface imrm_out_if;
  logic                          valid;
  logic                          ready;
  logic [imrm_pkg::EventW-1:0]   event_res;
  logic [imrm_pkg::HandleW-1:0]  source_handle;
  logic [imrm_pkg::HandleW-1:0]  dest_handle;
  logic [imrm_pkg::LenW-1:0]     transfer_length;
  logic [imrm_pkg::CookieW-1:0]  completion_info;
  logic                          last;
  modport source (output valid, event_res, source_handle, dest_handle, transfer_length,
                  completion_info, last, input ready);
  modport sink (input valid, event_res, source_handle, dest_handle, transfer_length,
                completion_info, last, output ready);
endinterface

/* rtl/core/imrm_cell.sv */
module imrm_cell (
  input  logic                clk,
  input  logic                rst,
  input  imrm_pkg::cell_ctrl_t ctrl,
  input  logic                hit_below,
  input  imrm_pkg::entry_t    from_next,
  input  logic                valid_next,
  input  imrm_pkg::entry_t    new_entry,
  input  logic                valid_prev,
  output imrm_pkg::entry_t    entry,
  output logic                valid
);

  // A cell at or above the removed entry takes its neighbour's content; the first
  // empty cell after the prefix takes the appended entry.
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (ctrl.shift && hit_below) begin
      valid <= valid_next;
      entry <= from_next;
    end else if (ctrl.append && !valid && valid_prev) begin
      valid <= 1'b1;
      entry <= new_entry;
    end
  end

endmodule

/* rtl/core/imrm_table.sv */
module imrm_table #(
  parameter int unsigned DEPTH = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  imrm_pkg::cell_ctrl_t ctrl,
  input  logic [DEPTH-1:0]    remove_mask,
  input  imrm_pkg::entry_t    new_entry,
  output imrm_pkg::entry_t    entries [DEPTH],
  output logic [DEPTH-1:0]    valids
);

  logic [DEPTH-1:0] at_or_above;

  always_comb begin
    at_or_above[0] = remove_mask[0];
    for (int i = 1; i < DEPTH; i++) begin
      at_or_above[i] = at_or_above[i-1] | remove_mask[i];
    end
  end

  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    imrm_pkg::entry_t nxt_e;
    logic             nxt_v;
    logic             prv_v;
    if (g == DEPTH - 1) begin : g_end
      assign nxt_e = entries[g];
      assign nxt_v = 1'b0;
    end else begin : g_mid
      assign nxt_e = entries[g+1];
      assign nxt_v = valids[g+1];
    end
    if (g == 0) begin : g_first
      assign prv_v = 1'b1;
    end else begin : g_rest
      assign prv_v = valids[g-1];
    end
    imrm_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .ctrl      (ctrl),
      .hit_below (at_or_above[g]),
      .from_next (nxt_e),
      .valid_next(nxt_v),
      .new_entry (new_entry),
      .valid_prev(prv_v),
      .entry     (entries[g]),
      .valid     (valids[g])
    );
  end

endmodule

/* rtl/core/ipc_message_request_matcher.sv */
// The first result is registered from the scan step after the input transfer; each
// further "buffer too small" result of a string send comes from a further scan step.
// A new item is accepted only in the idle state, after the scan of the request table,
// which reports one too-small match per cycle while the output is not stalled.
// Reset clears every valid bit of both tables and the output valid bit at once.
module ipc_message_request_matcher #(
  parameter int unsigned MESSAGE_DEPTH = 16,
  parameter int unsigned REQUEST_DEPTH = 16
) (
  input logic        clk,
  input logic        rst,
  imrm_in_if.sink    in_ch,
  imrm_out_if.source out_ch
);

  imrm_pkg::state_t state, state_next;

  logic                          op_r;
  imrm_pkg::entry_t              item;
  logic [REQUEST_DEPTH-1:0]      reported;

  imrm_pkg::entry_t  msg_e [MESSAGE_DEPTH];
  logic [MESSAGE_DEPTH-1:0] msg_v;
  imrm_pkg::entry_t  req_e [REQUEST_DEPTH];
  logic [REQUEST_DEPTH-1:0] req_v;

  logic [MESSAGE_DEPTH-1:0] msg_hit, msg_first;
  logic [REQUEST_DEPTH-1:0] req_hit, req_first;
  imrm_pkg::entry_t         msg_sel, req_sel;

  imrm_pkg::cell_ctrl_t     msg_ctrl, req_ctrl;
  logic [MESSAGE_DEPTH-1:0] msg_rm;
  logic [REQUEST_DEPTH-1:0] req_rm;
  logic                     act;

  logic                     o_valid, o_last;
  logic [imrm_pkg::EventW-1:0] o_ev, ev_c;
  logic [imrm_pkg::HandleW-1:0] o_src, o_dst, src_c, dst_c;
  logic [imrm_pkg::LenW-1:0]    o_len, len_c;
  logic [imrm_pkg::CookieW-1:0] o_ck, ck_c;
  logic                         last_c, emit_c, mrm_c, rrm_c, app_c, more_c;

  always_comb begin
    for (int i = 0; i < MESSAGE_DEPTH; i++) begin
      msg_hit[i] = msg_v[i] && msg_e[i].kind == item.kind
        && (item.tag == imrm_pkg::Wildcard || item.tag == msg_e[i].tag)
        && (item.seq == imrm_pkg::Wildcard || item.seq == msg_e[i].seq);
    end
    for (int i = 0; i < REQUEST_DEPTH; i++) begin
      req_hit[i] = req_v[i] && !reported[i] && req_e[i].kind == item.kind
        && (req_e[i].tag == imrm_pkg::Wildcard || req_e[i].tag == item.tag)
        && (req_e[i].seq == imrm_pkg::Wildcard || req_e[i].seq == item.seq);
    end
    msg_first = msg_hit & (~msg_hit + MESSAGE_DEPTH'(1));
    req_first = req_hit & (~req_hit + REQUEST_DEPTH'(1));
    msg_sel = '0;
    req_sel = '0;
    for (int i = 0; i < MESSAGE_DEPTH; i++) begin
      if (msg_first[i]) msg_sel = msg_e[i];
    end
    for (int i = 0; i < REQUEST_DEPTH; i++) begin
      if (req_first[i]) req_sel = req_e[i];
    end
  end

  // Decision for the current scan step.
  always_comb begin
    ev_c = imrm_pkg::EV_QUEUED;
    src_c = '0; dst_c = '0; len_c = '0; ck_c = '0;
    last_c = 1'b1; mrm_c = 1'b0; rrm_c = 1'b0; app_c = 1'b0; more_c = 1'b0;
    emit_c = state == imrm_pkg::ST_SCAN;
    if (!op_r) begin
      src_c = item.handle;
      if (|req_hit) begin
        dst_c = req_sel.handle;
        ck_c = req_sel.cookie;
        if (item.kind) begin
          ev_c = imrm_pkg::EV_DESC; rrm_c = 1'b1;
        end else if (item.len > req_sel.len) begin
          ev_c = imrm_pkg::EV_SMALL; len_c = item.len; last_c = 1'b0; more_c = 1'b1;
        end else begin
          ev_c = imrm_pkg::EV_XFER; len_c = item.len; rrm_c = 1'b1;
        end
      end else begin
        len_c = item.len;
        app_c = !msg_v[MESSAGE_DEPTH-1];
        ev_c = app_c ? imrm_pkg::EV_QUEUED : imrm_pkg::EV_DROP;
      end
    end else begin
      dst_c = item.handle;
      ck_c = item.cookie;
      if (|msg_hit) begin
        src_c = msg_sel.handle;
        if (item.kind) begin
          ev_c = imrm_pkg::EV_DESC; mrm_c = 1'b1;
        end else if (msg_sel.len > item.len) begin
          ev_c = imrm_pkg::EV_SMALL; len_c = msg_sel.len;
        end else begin
          ev_c = imrm_pkg::EV_XFER; len_c = msg_sel.len; mrm_c = 1'b1;
        end
      end else begin
        app_c = !req_v[REQUEST_DEPTH-1];
        ev_c = app_c ? imrm_pkg::EV_QUEUED : imrm_pkg::EV_DROP;
      end
    end
  end

  assign act = emit_c && (!o_valid || out_ch.ready);

  always_comb begin
    state_next = state;
    unique case (state)
      imrm_pkg::ST_IDLE: if (in_ch.valid) state_next = imrm_pkg::ST_SCAN;
      imrm_pkg::ST_SCAN: if (act && !more_c) state_next = imrm_pkg::ST_DONE;
      imrm_pkg::ST_EMIT: state_next = imrm_pkg::ST_SCAN;
      imrm_pkg::ST_DONE: state_next = imrm_pkg::ST_IDLE;
      default:           state_next = imrm_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    msg_ctrl.shift = act && mrm_c;
    msg_ctrl.append = act && app_c && !op_r;
    req_ctrl.shift = act && rrm_c;
    req_ctrl.append = act && app_c && op_r;
    msg_rm = msg_first;
    req_rm = req_first;
    in_ch.ready = state == imrm_pkg::ST_IDLE;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= imrm_pkg::ST_IDLE;
      o_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (act) begin
        o_valid <= 1'b1;
      end else if (out_ch.ready) begin
        o_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      op_r <= in_ch.op;
      item.kind <= in_ch.kind;
      item.tag <= in_ch.tag;
      item.seq <= in_ch.sequence_req;
      item.len <= in_ch.length;
      item.handle <= in_ch.payload_handle;
      item.cookie <= in_ch.request_cookie;
      reported <= '0;
    end else if (act && more_c) begin
      reported <= reported | req_first;
    end
    if (act) begin
      o_ev <= ev_c; o_src <= src_c; o_dst <= dst_c;
      o_len <= len_c; o_ck <= ck_c; o_last <= last_c;
    end
  end

  imrm_table #(.DEPTH(MESSAGE_DEPTH)) u_msg (
    .clk(clk), .rst(rst), .ctrl(msg_ctrl), .remove_mask(msg_rm),
    .new_entry(item), .entries(msg_e), .valids(msg_v)
  );

  imrm_table #(.DEPTH(REQUEST_DEPTH)) u_req (
    .clk(clk), .rst(rst), .ctrl(req_ctrl), .remove_mask(req_rm),
    .new_entry(item), .entries(req_e), .valids(req_v)
  );

  assign out_ch.valid = o_valid;
  assign out_ch.event_res = o_ev;
  assign out_ch.source_handle = o_src;
  assign out_ch.dest_handle = o_dst;
  assign out_ch.transfer_length = o_len;
  assign out_ch.completion_info = o_ck;
  assign out_ch.last = o_last;

  a_prefix_msg: assert property (@(posedge clk) disable iff (rst)
    ((msg_v >> 1) & ~msg_v) == '0) else $error("message table not a prefix");
  a_prefix_req: assert property (@(posedge clk) disable iff (rst)
    ((req_v >> 1) & ~req_v) == '0) else $error("request table not a prefix");
  a_one_shift: assert property (@(posedge clk) disable iff (rst)
    !(msg_ctrl.shift && req_ctrl.shift)) else $error("both tables shift");
  a_idle_ready: assert property (@(posedge clk) disable iff (rst)
    in_ch.valid && in_ch.ready |=> state == imrm_pkg::ST_SCAN)
    else $error("transfer did not start scan");

endmodule

/* tb/imrm_tb_if.sv */
`timescale 1ns / 1ps
package imrm_tb_pkg;
  import imrm_pkg::*;

  typedef struct {
    logic        op;
    logic        kind;
    logic [31:0] tag;
    logic [31:0] seq;
    logic [15:0] len;
    logic [15:0] handle;
    logic [31:0] cookie;
  } request_item_t;

  typedef struct {
    event_t      ev;
    logic [15:0] src;
    logic [15:0] dst;
    logic [15:0] len;
    logic [31:0] cookie;
    logic        last;
  } match_event_t;

  localparam logic OP_SEND = 1'b0;
  localparam logic OP_RECV = 1'b1;
  localparam logic KIND_STRING = 1'b0;
  localparam logic KIND_DESC = 1'b1;
endpackage

/* tb/imrm_checker.sv */
`timescale 1ns / 1ps
module imrm_checker
  import imrm_pkg::*;
  import imrm_tb_pkg::*;
#(
  parameter int MSG_DEPTH = 16,
  parameter int REQ_DEPTH = 16
) (
  input  logic       clk,
  input  logic       rst,
  imrm_in_if         in_ch,
  imrm_out_if        out_ch,
  output int         errors,
  output int         pending
);

  request_item_t msg_table[$];
  request_item_t req_table[$];
  match_event_t  expected_events[$];

  function automatic bit filter_hit(logic [31:0] ft, logic [31:0] fs,
                                    logic [31:0] t, logic [31:0] s);
    return (ft == Wildcard || ft == t) && (fs == Wildcard || fs == s);
  endfunction

  function automatic void push_event(event_t ev, logic [15:0] src, logic [15:0] dst,
                                     logic [15:0] len, logic [31:0] cookie);
    match_event_t e;
    e.ev = ev;
    e.src = src;
    e.dst = dst;
    e.len = len;
    e.cookie = cookie;
    e.last = 1'b0;
    expected_events.push_back(e);
  endfunction

  function automatic void predict_match(request_item_t it);
    request_item_t r;
    bit done;
    done = 0;
    if (it.op == OP_SEND) begin
      for (int i = 0; i < req_table.size() && !done; i++) begin
        r = req_table[i];
        if (r.kind == it.kind && filter_hit(r.tag, r.seq, it.tag, it.seq)) begin
          if (it.kind == KIND_DESC) begin
            push_event(EV_DESC, it.handle, r.handle, 16'd0, r.cookie);
            req_table.delete(i);
            done = 1;
          end else if (it.len > r.len) begin
            push_event(EV_SMALL, it.handle, r.handle, it.len, r.cookie);
          end else begin
            push_event(EV_XFER, it.handle, r.handle, it.len, r.cookie);
            req_table.delete(i);
            done = 1;
          end
        end
      end
      if (!done) begin
        if (msg_table.size() < MSG_DEPTH) begin
          msg_table.push_back(it);
          push_event(EV_QUEUED, it.handle, 16'd0, it.len, 32'd0);
        end else begin
          push_event(EV_DROP, it.handle, 16'd0, it.len, 32'd0);
        end
      end
    end else begin
      for (int i = 0; i < msg_table.size() && !done; i++) begin
        r = msg_table[i];
        if (r.kind == it.kind && filter_hit(it.tag, it.seq, r.tag, r.seq)) begin
          done = 1;
          if (it.kind == KIND_DESC) begin
            push_event(EV_DESC, r.handle, it.handle, 16'd0, it.cookie);
            msg_table.delete(i);
          end else if (r.len > it.len) begin
            push_event(EV_SMALL, r.handle, it.handle, r.len, it.cookie);
          end else begin
            push_event(EV_XFER, r.handle, it.handle, r.len, it.cookie);
            msg_table.delete(i);
          end
        end
      end
      if (!done) begin
        if (req_table.size() < REQ_DEPTH) begin
          req_table.push_back(it);
          push_event(EV_QUEUED, 16'd0, it.handle, 16'd0, it.cookie);
        end else begin
          push_event(EV_DROP, 16'd0, it.handle, 16'd0, it.cookie);
        end
      end
    end
    expected_events[$].last = 1'b1;
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("MISMATCH %s: got %0h, expected %0h", what, got, want);
    errors++;
  endtask

  initial errors = 0;
  assign pending = expected_events.size();

  always @(posedge clk) begin
    match_event_t e;
    request_item_t it;
    if (!rst) begin
      if (in_ch.valid && in_ch.ready) begin
        it.op = in_ch.op;
        it.kind = in_ch.kind;
        it.tag = in_ch.tag;
        it.seq = in_ch.sequence_req;
        it.len = in_ch.length;
        it.handle = in_ch.payload_handle;
        it.cookie = in_ch.request_cookie;
        predict_match(it);
      end
      if (out_ch.valid && out_ch.ready) begin
        if (expected_events.size() == 0) begin
          report_mismatch("unexpected result", out_ch.event_res, 0);
        end else begin
          e = expected_events.pop_front();
          if (out_ch.event_res !== e.ev) report_mismatch("event_res", out_ch.event_res, e.ev);
          if (out_ch.source_handle !== e.src)
            report_mismatch("source_handle", out_ch.source_handle, e.src);
          if (out_ch.dest_handle !== e.dst)
            report_mismatch("dest_handle", out_ch.dest_handle, e.dst);
          if (out_ch.transfer_length !== e.len)
            report_mismatch("transfer_length", out_ch.transfer_length, e.len);
          if (out_ch.completion_info !== e.cookie)
            report_mismatch("completion_info", out_ch.completion_info, e.cookie);
          if (out_ch.last !== e.last) report_mismatch("last", out_ch.last, e.last);
        end
      end
    end
  end

endmodule

/* tb/tb_ipc_message_request_matcher.sv */
`timescale 1ns / 1ps
module tb_ipc_message_request_matcher;
  import imrm_pkg::*;
  import imrm_tb_pkg::*;

  logic clk = 1'b0;
  logic rst = 1'b1;
  int   errors;
  int   pending;
  bit   hold_off = 1'b0;

  imrm_in_if  in_ch ();
  imrm_out_if out_ch ();

  always #2 clk = ~clk;

  ipc_message_request_matcher dut (
    .clk   (clk),
    .rst   (rst),
    .in_ch (in_ch),
    .out_ch(out_ch)
  );

  imrm_checker checker_i (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .errors (errors),
    .pending(pending)
  );

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic logic [31:0] pick_filter(bit recv);
    int r;
    r = $urandom_range(0, 9);
    if (recv && r < 3) return Wildcard;
    if (r == 9) return $urandom();
    if (r == 8) return Wildcard;
    return $urandom_range(0, 3);
  endfunction

  task automatic send_item(request_item_t it);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.op <= it.op;
    in_ch.kind <= it.kind;
    in_ch.tag <= it.tag;
    in_ch.sequence_req <= it.seq;
    in_ch.length <= it.len;
    in_ch.payload_handle <= it.handle;
    in_ch.request_cookie <= it.cookie;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  task automatic make_item(input logic op, input logic kind, input logic [31:0] tag,
                           input logic [31:0] seq, input logic [15:0] len,
                           output request_item_t it);
    it.op = op;
    it.kind = kind;
    it.tag = tag;
    it.seq = seq;
    it.len = len;
    it.handle = 16'($urandom());
    it.cookie = $urandom();
  endtask

  initial begin
    in_ch.valid = 1'b0;
    in_ch.op = 1'b0;
    in_ch.kind = 1'b0;
    in_ch.tag = '0;
    in_ch.sequence_req = '0;
    in_ch.length = '0;
    in_ch.payload_handle = '0;
    in_ch.request_cookie = '0;
    out_ch.ready = 1'b0;
  end

  always @(posedge clk) begin
    int stall;
    if (rst || hold_off) begin
      out_ch.ready <= 1'b0;
    end else begin
      stall = pick_gap();
      if (stall == 0) begin
        out_ch.ready <= 1'b1;
      end else begin
        out_ch.ready <= 1'b0;
        repeat (stall - 1) @(posedge clk);
      end
    end
  end

  initial begin
    request_item_t it;
    int wait_cycles;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    make_item(OP_RECV, KIND_STRING, 32'd5, 32'd5, 16'd10, it); send_item(it);
    make_item(OP_RECV, KIND_STRING, Wildcard, 32'd5, 16'd100, it); send_item(it);
    make_item(OP_SEND, KIND_STRING, 32'd5, 32'd5, 16'd50, it); send_item(it);
    make_item(OP_SEND, KIND_STRING, 32'd5, 32'd5, 16'hFFFF, it); send_item(it);
    make_item(OP_RECV, KIND_STRING, 32'd5, Wildcard, 16'd10, it); send_item(it);
    make_item(OP_RECV, KIND_STRING, 32'd5, Wildcard, 16'hFFFF, it); send_item(it);
    make_item(OP_SEND, KIND_DESC, Wildcard, Wildcard, 16'd0, it); send_item(it);
    make_item(OP_RECV, KIND_DESC, Wildcard, Wildcard, 16'd0, it); send_item(it);
    make_item(OP_RECV, KIND_DESC, 32'h7FFFFFFF, 32'd0, 16'd0, it); send_item(it);
    make_item(OP_SEND, KIND_DESC, 32'h7FFFFFFF, 32'd0, 16'hFFFF, it); send_item(it);
    make_item(OP_SEND, KIND_STRING, 32'h80000000, 32'h7FFFFFFF, 16'd0, it); send_item(it);
    it.handle = 16'hFFFF; it.cookie = 32'hFFFFFFFF; send_item(it);
    for (int i = 0; i < 18; i++) begin
      make_item(OP_SEND, i[0], 32'd9, 32'd9, 16'd1, it);
      send_item(it);
    end
    for (int i = 0; i < 18; i++) begin
      make_item(OP_RECV, KIND_STRING, 32'd77, 32'd77, 16'd0, it);
      send_item(it);
    end
    make_item(OP_SEND, KIND_STRING, 32'd77, 32'd77, 16'd1, it); send_item(it);

    // Drain both tables so that the random part starts from varied occupancy.
    for (int i = 0; i < 16; i++) begin
      make_item(OP_RECV, i[0], Wildcard, Wildcard, 16'hFFFF, it);
      send_item(it);
    end
    for (int i = 0; i < 16; i++) begin
      make_item(OP_SEND, KIND_STRING, 32'd77, 32'd77, 16'd0, it);
      send_item(it);
    end

    fork
      begin
        for (int i = 0; i < 120; i++) begin
          logic op;
          op = 1'($urandom_range(0, 1));
          make_item(op, ($urandom_range(0, 3) == 0), pick_filter(op), pick_filter(op),
                    ($urandom_range(0, 7) == 0) ? 16'($urandom()) : 16'($urandom_range(0, 20)),
                    it);
          send_item(it);
        end
        in_ch.valid <= 1'b0;
      end
      begin
        repeat (300) @(posedge clk);
        hold_off <= 1'b1;
        repeat (200) @(posedge clk);
        hold_off <= 1'b0;
      end
    join

    wait_cycles = 0;
    while (pending != 0 && wait_cycles < 100000) begin
      @(posedge clk);
      wait_cycles++;
    end
    repeat (20) @(posedge clk);
    if (errors == 0 && pending == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule

/* files.f */
rtl/core/imrm_pkg.sv
rtl/core/imrm_if.sv
rtl/core/imrm_cell.sv
rtl/core/imrm_table.sv
rtl/core/ipc_message_request_matcher.sv
tb/imrm_tb_if.sv
tb/imrm_checker.sv
tb/tb_ipc_message_request_matcher.sv
